>>> design/ps2kb_pkg.sv
package ps2kb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_PERIOD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_DELAY    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_DELAY  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CODES    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_CMD    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK_PREFIX = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLY_CODES  = 3'd7;

   localparam int ENTRY_W = 11;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_BAT  = 2'd2;

   typedef struct packed {
      logic       clk_in;
      logic       data_in;
      logic [3:0] key_levels;
   } tick_type;

endpackage

>>> design/ps2_keyboard_device_port_unit.sv
// A tick's result is in the result queue in the cycle after the tick is taken.
// One tick per cycle, as long as the two-entry result queue has room;
// the scancode queue, link timers and key scan all update in the accepting cycle.
// Reset: synchronous, active high; registers return to their default values,
// the scancode queue is emptied and the link goes idle. No clearing pass.
module ps2_keyboard_device_port_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_clk_in,
   input  logic                                req_data_in,
   input  logic [3:0]                          req_key_levels,
   output logic                                empty,
   input  logic                                pop,
   output logic                                rsp_clk_drive_low,
   output logic                                rsp_data_drive_low,
   output logic                                rsp_led_on,
   output logic                                rsp_busy_res,
   output logic                                rsp_queue_overflow,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]  rsp_queue_count,
   input  logic                                csr_write_en,
   input  logic [ps2kb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ps2kb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ps2kb_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = CW + 5;

   tick_type      tick;
   logic          tick_en;
   logic          c_clk, c_dat, c_led, c_busy, c_ovf;
   logic [CW-1:0] c_cnt;
   logic [RW-1:0] rsp_data;

   assign tick    = '{clk_in: req_clk_in, data_in: req_data_in, key_levels: req_key_levels};
   assign tick_en = push && !full;

   ps2kb_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .CW         (CW)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .tick_en       (tick_en),
      .tick          (tick),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .clk_drive_low (c_clk),
      .data_drive_low(c_dat),
      .led_on        (c_led),
      .busy_res      (c_busy),
      .queue_overflow(c_ovf),
      .queue_count   (c_cnt)
   );

   ps2kb_rsp_fifo #(
      .WIDTH(RW)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (tick_en),
      .wr_data({c_clk, c_dat, c_led, c_busy, c_ovf, c_cnt}),
      .full   (full),
      .rd_en  (pop),
      .empty  (empty),
      .rd_data(rsp_data)
   );

   assign {rsp_clk_drive_low, rsp_data_drive_low, rsp_led_on, rsp_busy_res,
           rsp_queue_overflow, rsp_queue_count} = rsp_data;
endmodule

>>> design/ps2kb_rsp_fifo.sv
module ps2kb_rsp_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = slot_ff[rptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wptr_in  = do_wr ? ~wptr_ff : wptr_ff;
      rptr_in  = do_rd ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end
endmodule

>>> design/ps2kb_core.sv
module ps2kb_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CW          = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_en,
   input  ps2kb_pkg::tick_type         tick,
   input  logic                        csr_write_en,
   input  logic [ps2kb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ps2kb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                        clk_drive_low,
   output logic                        data_drive_low,
   output logic                        led_on,
   output logic                        busy_res,
   output logic                        queue_overflow,
   output logic [CW-1:0]               queue_count
);
   import ps2kb_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [3:0] PH_IDLE         = 4'd0;
   localparam logic [3:0] PH_DELAY        = 4'd1;
   localparam logic [3:0] PH_TX_SETUP     = 4'd2;
   localparam logic [3:0] PH_TX_LOW       = 4'd3;
   localparam logic [3:0] PH_TX_HIGH      = 4'd4;
   localparam logic [3:0] PH_RX_WAIT      = 4'd5;
   localparam logic [3:0] PH_RX_LOW       = 4'd6;
   localparam logic [3:0] PH_RX_HIGH      = 4'd7;
   localparam logic [3:0] PH_ACK_SETUP    = 4'd8;
   localparam logic [3:0] PH_ACK_LOW      = 4'd9;
   localparam logic [3:0] PH_ACK_HIGH     = 4'd10;
   localparam logic [3:0] PH_RELEASE_WAIT = 4'd11;

   logic [15:0] half_ff, full_ff, ackd_ff, rstd_ff;
   logic [31:0] keycodes_ff;
   logic [7:0]  rstcmd_ff, brk_ff;
   logic [15:0] reply_ff;

   logic [ENTRY_W-1:0] q_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] q_in [QUEUE_DEPTH];
   logic [AW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [3:0]         phase_ff, phase_in;
   logic [3:0]         bitcnt_ff, bitcnt_in;
   logic [7:0]         shift_ff, shift_in;
   logic               parity_ff, parity_in;
   logic [15:0]        timer_ff, timer_in;
   logic [3:0]         keys_ff, keys_in;
   logic               led_ff, led_in;

   logic [3:0]         diff;
   logic [1:0]         key_idx;
   logic [7:0]         make_code;
   logic               push_req [4];
   logic [ENTRY_W-1:0] push_val [4];
   logic               ovf;
   logic               timer_done;
   logic [ENTRY_W-1:0] entry;
   logic [15:0]        delay;
   logic               txb;

   assign timer_done = (timer_ff <= 16'd1);

   always_comb begin
      diff      = tick.key_levels ^ keys_ff;
      key_idx   = diff[0] ? 2'd0 : diff[1] ? 2'd1 : diff[2] ? 2'd2 : 2'd3;
      case (key_idx)
         2'd0:    make_code = keycodes_ff[7:0];
         2'd1:    make_code = keycodes_ff[15:8];
         2'd2:    make_code = keycodes_ff[23:16];
         default: make_code = keycodes_ff[31:24];
      endcase
      keys_in = keys_ff;
      led_in  = led_ff;
      if (diff != 4'd0) begin
         keys_in[key_idx] = ~keys_ff[key_idx];
         led_in           = ~led_ff;
      end

      // Slots in push order: key codes first, then the acknowledge and BAT replies.
      push_req[0] = (diff != 4'd0);
      push_val[0] = tick.key_levels[key_idx] ? {KIND_NONE, make_code}
                                             : {KIND_NONE, brk_ff};
      push_req[1] = (diff != 4'd0) && !tick.key_levels[key_idx];
      push_val[1] = {KIND_NONE, make_code};
      push_req[2] = (phase_ff == PH_ACK_HIGH) && timer_done;
      push_val[2] = {KIND_ACK, reply_ff[7:0]};
      push_req[3] = push_req[2] && (shift_ff == rstcmd_ff);
      push_val[3] = {KIND_BAT, reply_ff[15:8]};

      q_in    = q_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      ovf     = 1'b0;
      for (int s = 0; s < 4; s++) begin
         if (push_req[s]) begin
            if (cnt_in < CW'(QUEUE_DEPTH)) begin
               q_in[tail_in] = push_val[s];
               tail_in = (tail_in == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_in + 1'b1;
               cnt_in  = cnt_in + 1'b1;
            end else begin
               ovf = 1'b1;
            end
         end
      end

      head_in   = head_ff;
      phase_in  = phase_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      parity_in = parity_ff;
      timer_in  = timer_ff;
      entry     = q_in[head_ff];
      delay     = (entry[9:8] == KIND_ACK) ? ackd_ff :
                  (entry[9:8] == KIND_BAT) ? rstd_ff : 16'd0;

      case (phase_ff)
         PH_IDLE: begin
            if (tick.clk_in && tick.data_in) begin
               if (cnt_in != '0) begin
                  head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  cnt_in   = cnt_in - 1'b1;
                  shift_in = entry[7:0];
                  if (delay != 16'd0) begin
                     timer_in = delay;
                     phase_in = PH_DELAY;
                  end else begin
                     parity_in = ~(^entry[7:0]);
                     bitcnt_in = 4'd0;
                     timer_in  = half_ff;
                     phase_in  = PH_TX_SETUP;
                  end
               end
            end else if (!tick.clk_in && !tick.data_in) begin
               phase_in = PH_RX_WAIT;
            end
         end
         PH_DELAY: begin
            if (timer_done) begin
               parity_in = ~(^shift_ff);
               bitcnt_in = 4'd0;
               timer_in  = half_ff;
               phase_in  = PH_TX_SETUP;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_TX_SETUP, PH_ACK_SETUP: begin
            if (timer_done) begin
               phase_in = (phase_ff == PH_TX_SETUP) ? PH_TX_LOW : PH_ACK_LOW;
               timer_in = full_ff;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_TX_LOW: begin
            if (timer_done) begin
               if (bitcnt_ff >= 4'd10) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_TX_HIGH;
                  timer_in = half_ff;
               end
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_TX_HIGH: begin
            if (timer_done) begin
               bitcnt_in = bitcnt_ff + 1'b1;
               phase_in  = PH_TX_SETUP;
               timer_in  = half_ff;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_RX_WAIT: begin
            if (tick.clk_in) begin
               phase_in  = PH_RX_LOW;
               timer_in  = full_ff;
               bitcnt_in = 4'd0;
            end
         end
         PH_RX_LOW: begin
            if (timer_done) begin
               if (bitcnt_ff < 4'd8) begin
                  shift_in = {tick.data_in, shift_ff[7:1]};
               end
               phase_in = PH_RX_HIGH;
               timer_in = full_ff;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_RX_HIGH: begin
            if (timer_done) begin
               bitcnt_in = bitcnt_ff + 1'b1;
               if (bitcnt_in >= 4'd10) begin
                  phase_in = PH_ACK_SETUP;
                  timer_in = half_ff;
               end else begin
                  phase_in = PH_RX_LOW;
                  timer_in = full_ff;
               end
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_ACK_LOW: begin
            if (timer_done) begin
               phase_in = PH_ACK_HIGH;
               timer_in = half_ff;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_ACK_HIGH: begin
            if (timer_done) begin
               phase_in = PH_RELEASE_WAIT;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_RELEASE_WAIT: begin
            if (tick.clk_in && tick.data_in) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      if (bitcnt_in == 4'd0) begin
         txb = 1'b0;
      end else if (bitcnt_in <= 4'd8) begin
         txb = shift_in[3'(bitcnt_in - 4'd1)];
      end else if (bitcnt_in == 4'd9) begin
         txb = parity_in;
      end else begin
         txb = 1'b1;
      end

      clk_drive_low  = (phase_in == PH_TX_LOW) || (phase_in == PH_RX_LOW) ||
                       (phase_in == PH_ACK_LOW);
      data_drive_low = (((phase_in == PH_TX_SETUP) || (phase_in == PH_TX_LOW) ||
                         (phase_in == PH_TX_HIGH)) && !txb) ||
                       (phase_in == PH_ACK_SETUP) || (phase_in == PH_ACK_LOW) ||
                       (phase_in == PH_ACK_HIGH);
      busy_res       = (phase_in >= PH_TX_SETUP) && (phase_in <= PH_ACK_HIGH);
      led_on         = led_in;
      queue_overflow = ovf;
      queue_count    = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= 16'd20;
         full_ff     <= 16'd40;
         ackd_ff     <= 16'd0;
         rstd_ff     <= 16'd1000;
         keycodes_ff <= 32'h2321_231C;
         rstcmd_ff   <= 8'hFF;
         brk_ff      <= 8'hF0;
         reply_ff    <= 16'hAAFA;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_HALF_PERIOD:  half_ff     <= csr_wdata[15:0];
            CSR_FULL_PERIOD:  full_ff     <= csr_wdata[15:0];
            CSR_ACK_DELAY:    ackd_ff     <= csr_wdata[15:0];
            CSR_RESET_DELAY:  rstd_ff     <= csr_wdata[15:0];
            CSR_KEY_CODES:    keycodes_ff <= csr_wdata;
            CSR_RESET_CMD:    rstcmd_ff   <= csr_wdata[7:0];
            CSR_BREAK_PREFIX: brk_ff      <= csr_wdata[7:0];
            CSR_REPLY_CODES:  reply_ff    <= csr_wdata[15:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
         phase_ff  <= PH_IDLE;
         bitcnt_ff <= 4'd0;
         shift_ff  <= 8'd0;
         parity_ff <= 1'b1;
         timer_ff  <= 16'd0;
         keys_ff   <= 4'd0;
         led_ff    <= 1'b0;
      end else if (tick_en) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         bitcnt_ff <= bitcnt_in;
         shift_ff  <= shift_in;
         parity_ff <= parity_in;
         timer_ff  <= timer_in;
         keys_ff   <= keys_in;
         led_ff    <= led_in;
      end
      if (tick_en) begin
         q_ff <= q_in;
      end
   end
endmodule
